// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL, included by int_to_ascii_dec_hex.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition must never hold.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== design/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

   // Width of the integer operand
   localparam int VALUE_BITS = 31;

   // Digit slots: enough for every decimal and hex rendering of the operand
   localparam int DEC_DIGITS     = (VALUE_BITS * 30103) / 100000 + 2;
   localparam int HEX_DIGITS     = (VALUE_BITS + 3) / 4;
   localparam int NUM_DIGITS     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DIGIT_IDX_BITS = $clog2(NUM_DIGITS);
   localparam int BIT_CNT_BITS   = $clog2(VALUE_BITS + 1);
   localparam int CHAR_BITS      = 7;

   // Character codes and digit/BCD constants
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_X       = 7'h78;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [3:0]           DIGIT_TEN    = 4'd10;
   localparam logic [3:0]           DIGIT_NINE   = 4'd9;
   localparam logic [3:0]           BCD_LIMIT    = 4'd4;
   localparam logic [3:0]           BCD_ADJUST   = 4'd3;

   typedef logic [NUM_DIGITS-1:0][3:0] digit_vec_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  hex_mode;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_char;
   } rsp_type;

   // Control from the sequencer to the conversion unit
   typedef struct packed {
      logic                  start;
      logic                  hex_mode;
      logic [VALUE_BITS-1:0] value;
   } conv_ctrl_type;

   // Status back from the conversion unit
   typedef struct packed {
      logic busy;
      logic done;
   } conv_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_PREFIX0,
      ST_PREFIXX,
      ST_DIGIT
   } state_type;

   // One digit (0..15) to its upper-case ASCII character
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DIGIT_TEN) begin
         c = CHAR_ZERO + {3'd0, d};
      end else begin
         c = CHAR_UPPER_A + {3'd0, d - DIGIT_TEN};
      end
      return c;
   endfunction

endpackage

// ===== design/itoa_conv.sv =====
`timescale 1ns / 1ps

// Digit converter: shift-and-add-3 (one operand bit per cycle) for decimal,
// direct nibble load for hex. Digits are left in a register for the sequencer.
module itoa_conv import itoa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  conv_ctrl_type ctrl,
   output conv_stat_type stat,
   output digit_vec_type digits
);

   digit_vec_type           bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0]   shift_ff, shift_in;
   logic [BIT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   digit_vec_type           adj;
   logic [NUM_DIGITS*4:0]   shifted;

   // Add-3 correction on every digit at or above five
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] > BCD_LIMIT) ? bcd_ff[i] + BCD_ADJUST : bcd_ff[i];
      end
   end

   // Corrected digits shifted left with the next operand bit
   assign shifted = {adj, shift_ff[VALUE_BITS-1]};

   // Next-state for the conversion datapath
   always_comb begin
      bcd_in   = bcd_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         if (ctrl.hex_mode) begin
            bcd_in  = digit_vec_type'((NUM_DIGITS * 4)'(ctrl.value));
            done_in = 1'b1;
         end else begin
            bcd_in   = '0;
            shift_in = ctrl.value;
            cnt_in   = BIT_CNT_BITS'(VALUE_BITS);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         bcd_in   = digit_vec_type'(shifted[NUM_DIGITS*4-1:0]);
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff - BIT_CNT_BITS'(1);
         if (cnt_ff == BIT_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bcd_ff   <= bcd_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   assign digits    = bcd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== design/int_to_ascii_dec_hex.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Integer to ASCII text converter. Each request transaction carries a
// VALUE_BITS-wide unsigned value and a hex flag; the block answers with one
// response transaction per character, most significant digit first, with
// last_char set on the final one. Hex text gets a "0x" prefix and digits A-F;
// zero is always the single character "0". Per request: in decimal the
// shift-and-add-3 unit works through all VALUE_BITS operand bits, in hex the
// digits are loaded directly; then a leading-zero scan steps one digit slot
// per cycle over up to NUM_DIGITS slots (11), and the characters leave one
// per cycle when the consumer is ready. The block accepts no new request
// until the last character has been loaded into the response register.
module int_to_ascii_dec_hex import itoa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type                 state_ff, state_in;
   logic [DIGIT_IDX_BITS-1:0] idx_ff, idx_in;
   logic                      hex_ff, hex_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   conv_ctrl_type             conv_ctrl;
   conv_stat_type             conv_stat;
   digit_vec_type             digits;
   logic [3:0]                cur_digit;
   logic                      out_free;
   logic                      load;

   itoa_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (conv_ctrl),
      .stat   (conv_stat),
      .digits (digits)
   );

   assign cur_digit = digits[idx_ff];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Sequencer: convert, skip leading zeros, emit prefix and digits
   always_comb begin
      state_in           = state_ff;
      idx_in             = idx_ff;
      hex_in             = hex_ff;
      req_ready          = 1'b0;
      load               = 1'b0;
      rsp_data_in        = rsp_data_ff;
      conv_ctrl.start    = 1'b0;
      conv_ctrl.hex_mode = req_data.hex_mode;
      conv_ctrl.value    = req_data.value;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               conv_ctrl.start = 1'b1;
               hex_in          = req_data.hex_mode;
               idx_in          = DIGIT_IDX_BITS'(NUM_DIGITS - 1);
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit == 4'd0 && idx_ff != '0) begin
               idx_in = idx_ff - DIGIT_IDX_BITS'(1);
            end else if (hex_ff && cur_digit != 4'd0) begin
               state_in = ST_PREFIX0;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_PREFIX0: begin
            if (out_free) begin
               load                  = 1'b1;
               rsp_data_in.char_code = CHAR_ZERO;
               rsp_data_in.last_char = 1'b0;
               state_in              = ST_PREFIXX;
            end
         end
         ST_PREFIXX: begin
            if (out_free) begin
               load                  = 1'b1;
               rsp_data_in.char_code = CHAR_X;
               rsp_data_in.last_char = 1'b0;
               state_in              = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               load                  = 1'b1;
               rsp_data_in.char_code = digit_char(cur_digit);
               rsp_data_in.last_char = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - DIGIT_IDX_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      hex_ff      <= hex_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Conversion finishes only while the sequencer waits for it
   `ASSERT_IMPLY(a_done_in_conv, clock, reset, conv_stat.done, state_ff == ST_CONV,
      "conversion done outside wait state")

   // Decimal digits stay in BCD range
   `ASSERT_IMPLY(a_bcd_range, clock, reset, state_ff == ST_DIGIT && !hex_ff,
      cur_digit <= DIGIT_NINE, "decimal digit out of range")

   // The hex prefix is never the final character
   `ASSERT_IMPLY(a_prefix_not_last, clock, reset,
      rsp_valid_ff && (state_ff == ST_PREFIXX || state_ff == ST_DIGIT) && hex_ff
         && rsp_data_ff.char_code == CHAR_X,
      !rsp_data_ff.last_char, "prefix marked as last character")

   // No conversion is started while one is running
   `ASSERT_NEVER(a_no_restart, clock, reset, conv_stat.busy && conv_ctrl.start,
      "conversion started while busy")

   // After the final character is loaded the block returns to idle
   `ASSERT_NEXT(a_last_to_idle, clock, reset, load && rsp_data_in.last_char,
      state_ff == ST_IDLE && rsp_valid_ff && rsp_data_ff.last_char,
      "final character did not end the transaction")

endmodule

// ===== verif/tb_int_to_ascii_dec_hex.sv =====
`timescale 1ns / 1ps

module tb_int_to_ascii_dec_hex;
   import itoa_pkg::*;

   localparam logic [CHAR_BITS-1:0] ASC_ZERO  = 7'h30;
   localparam logic [CHAR_BITS-1:0] ASC_UPPER = 7'h41;
   localparam logic [CHAR_BITS-1:0] ASC_X     = 7'h78;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int ITEMS_PER_PHASE = 80;

   // Expected characters per accepted number, checked in arrival order
   class text_scoreboard;
      rsp_type pending_chars[$];
      int      n_errors;

      function new();
         n_errors = 0;
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction

      // Render one accepted number as its expected character stream
      function void note_number(req_type r);
         logic [VALUE_BITS-1:0] v;
         logic [3:0]            digs[$];
         int                    radix;
         rsp_type               c;
         v = r.value;
         if (v == '0) begin
            c.char_code = ASC_ZERO;
            c.last_char = 1'b1;
            pending_chars.push_back(c);
            return;
         end
         radix = r.hex_mode ? 16 : 10;
         while (v != '0) begin
            digs.push_back(4'(v % radix));
            v = VALUE_BITS'(v / radix);
         end
         if (r.hex_mode) begin
            c.last_char = 1'b0;
            c.char_code = ASC_ZERO;
            pending_chars.push_back(c);
            c.char_code = ASC_X;
            pending_chars.push_back(c);
         end
         for (int i = digs.size() - 1; i >= 0; i--) begin
            if (digs[i] < 4'd10) begin
               c.char_code = ASC_ZERO + CHAR_BITS'(digs[i]);
            end else begin
               c.char_code = ASC_UPPER + CHAR_BITS'(digs[i] - 4'd10);
            end
            c.last_char = (i == 0);
            pending_chars.push_back(c);
         end
      endfunction

      // Compare one response transaction with the oldest expectation
      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            $error("unexpected character: char_code=%0h last_char=%0b",
                   got.char_code, got.last_char);
            n_errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.char_code !== want.char_code) begin
            $error("char_code mismatch: expected %0h, actual %0h",
                   want.char_code, got.char_code);
            n_errors++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char mismatch: expected %0b, actual %0b",
                   want.last_char, got.last_char);
            n_errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   text_scoreboard sb;
   int tx_idle_pct;
   int rx_idle_pct;
   bit hold_rx_req;

   int_to_ascii_dec_hex u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rx_req) begin
            hold_left = HOLD_CYCLES;
            hold_rx_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_data);
      end
   end

   function automatic req_type make_req(logic [VALUE_BITS-1:0] v, logic hex);
      req_type r;
      r.value = v;
      r.hex_mode = hex;
      return r;
   endfunction

   // Random operand: mostly shortened values so every digit count shows up
   function automatic req_type rand_req();
      logic [VALUE_BITS-1:0] v;
      int kind;
      kind = $urandom_range(19, 0);
      if (kind == 0) begin
         v = '0;
      end else if (kind == 1) begin
         v = '1;
      end else begin
         v = VALUE_BITS'($urandom()) >> $urandom_range(VALUE_BITS - 1, 0);
      end
      return make_req(v, 1'($urandom_range(1, 0)));
   endfunction

   // Offer one request transaction, with random gaps before it
   task automatic send_number(input req_type r);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data <= req_type'($urandom());
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_number(r);
   endtask

   // Stop offering and wait until every expected character is out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_number(rand_req());
      end
   endtask

   initial begin
      sb = new();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_rx_req = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero in both modes, digit-count boundaries, full width
      send_number(make_req(31'd0, 1'b0));
      send_number(make_req(31'd0, 1'b1));
      send_number(make_req(31'd1, 1'b0));
      send_number(make_req(31'd1, 1'b1));
      send_number(make_req(31'd9, 1'b0));
      send_number(make_req(31'd10, 1'b0));
      send_number(make_req(31'd15, 1'b1));
      send_number(make_req(31'd16, 1'b1));
      send_number(make_req(31'd99, 1'b0));
      send_number(make_req(31'd100, 1'b0));
      send_number(make_req(31'hFF, 1'b1));
      send_number(make_req(31'd999999999, 1'b0));
      send_number(make_req(31'd1000000000, 1'b0));
      send_number(make_req(31'h7FFFFFFF, 1'b0));
      send_number(make_req(31'h7FFFFFFF, 1'b1));
      send_number(make_req(31'h10000000, 1'b1));
      send_number(make_req(31'h0FFFFFFF, 1'b1));
      send_number(make_req(31'h2AAAAAAA, 1'b1));
      send_number(make_req(31'h55555555, 1'b0));
      send_number(make_req(31'h00ABCDEF, 1'b1));
      send_number(make_req(31'h01234567, 1'b0));

      // Receiver idles more than sender
      tx_idle_pct = 22;
      rx_idle_pct = 46;
      send_random(ITEMS_PER_PHASE);

      // Sender stops until every character is out
      wait_drained();

      // Sender idles more than receiver
      tx_idle_pct = 46;
      rx_idle_pct = 22;
      send_random(ITEMS_PER_PHASE);

      // Full rate, with a long receiver hold-off that backs up the input
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      @(posedge clock);
      hold_rx_req = 1'b1;
      send_random(8);
      send_random(ITEMS_PER_PHASE);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
